### rtl/stre_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stre_pkg
// Shared codes, constants and types of the servo telemetry read engine.
// ----------------------------------------------------------------------------
package stre_pkg;

    // Input command codes (value 3 is ignored)
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    // Status response framing
    localparam int RSP_BYTES     = 14;
    localparam int DATA_FIRST    = 5;
    localparam int DATA_BYTES    = 8;
    localparam logic [7:0] HDR_BYTE = 8'hFF;

    // Read request fields
    localparam logic [7:0] REQ_LEN_FIELD = 8'h04;
    localparam logic [7:0] REQ_INSTR     = 8'h02;
    localparam logic [7:0] REQ_ADDR      = 8'h38;
    localparam logic [7:0] REQ_COUNT     = 8'h08;

    // Report conversion
    localparam logic [16:0] CENTER_STEPS  = 17'd2047;
    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
    localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

    // Completion of a response, from the collector to the top level
    typedef struct packed {
        logic done;
        logic ok;
    } t_rx_event;

endpackage
`default_nettype wire

### rtl/stre_rx_collect.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stre_rx_collect
// Response collector: tracks the wait phase, stores response bytes, keeps a
// running header check and checksum, and counts ticks against the timeout.
// ----------------------------------------------------------------------------
module stre_rx_collect (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [1:0]           i_cmd,
    input  wire logic [7:0]           i_servo_id,
    input  wire logic [7:0]           i_rx_byte,
    input  wire logic [15:0]          i_timeout,
    output stre_pkg::t_rx_event       o_event,
    output logic [7:0][7:0]           o_data
);
    import stre_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'b01,
        PH_WAIT = 2'b10
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_exp_id, n_exp_id;
    logic [3:0]  r_idx, n_idx;
    logic [15:0] r_elapsed, n_elapsed;
    logic [7:0]  r_sum, n_sum;
    logic        r_hdr_ok, n_hdr_ok;
    logic [7:0]  r_store [RSP_BYTES];

    logic        store_we;
    logic [15:0] tick_next;

    // Next state and completion event
    always_comb begin
        n_phase   = r_phase;
        n_exp_id  = r_exp_id;
        n_idx     = r_idx;
        n_elapsed = r_elapsed;
        n_sum     = r_sum;
        n_hdr_ok  = r_hdr_ok;
        store_we  = 1'b0;
        o_event   = '0;
        tick_next = (r_elapsed == TICKS_MAX) ? r_elapsed : r_elapsed + 16'd1;

        if (i_accept) begin
            if (i_cmd == CMD_START) begin
                n_phase   = PH_WAIT;
                n_exp_id  = i_servo_id;
                n_idx     = '0;
                n_elapsed = '0;
                n_sum     = '0;
                n_hdr_ok  = 1'b1;
            end else if (r_phase == PH_WAIT && i_cmd == CMD_BYTE) begin
                store_we = 1'b1;
                n_idx    = r_idx + 4'd1;
                // header bytes and id
                if ((r_idx == 4'd0 || r_idx == 4'd1) && i_rx_byte != HDR_BYTE) begin
                    n_hdr_ok = 1'b0;
                end
                if (r_idx == 4'd2 && i_rx_byte != r_exp_id) begin
                    n_hdr_ok = 1'b0;
                end
                // checksum covers bytes 2 through the one before the last
                if (r_idx >= 4'd2 && r_idx <= 4'(RSP_BYTES - 2)) begin
                    n_sum = r_sum + i_rx_byte;
                end
                if (r_idx == 4'(RSP_BYTES - 1)) begin
                    o_event.done = 1'b1;
                    o_event.ok   = r_hdr_ok && (i_rx_byte == ~r_sum);
                    n_phase      = PH_IDLE;
                    n_idx        = '0;
                    n_elapsed    = '0;
                end
            end else if (r_phase == PH_WAIT && i_cmd == CMD_TICK) begin
                n_elapsed = tick_next;
                if (tick_next >= i_timeout) begin
                    o_event.done = 1'b1;
                    o_event.ok   = 1'b0;
                    n_phase      = PH_IDLE;
                    n_idx        = '0;
                    n_elapsed    = '0;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_exp_id  <= '0;
            r_idx     <= '0;
            r_elapsed <= '0;
            r_sum     <= '0;
            r_hdr_ok  <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_exp_id  <= n_exp_id;
            r_idx     <= n_idx;
            r_elapsed <= n_elapsed;
            r_sum     <= n_sum;
            r_hdr_ok  <= n_hdr_ok;
        end
    end

    // Response byte store
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_idx] <= i_rx_byte;
        end
    end

    // Data bytes of the response, fixed taps
    always_comb begin
        for (int k = 0; k < DATA_BYTES; k++) begin
            o_data[k] = r_store[DATA_FIRST + k];
        end
    end

endmodule
`default_nettype wire

### rtl/servo_telemetry_read_engine_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// servo_telemetry_read_engine_top
// Servo read request generator and status response decoder.
// ----------------------------------------------------------------------------
// A start item (tuser 0) makes the block send the 8-byte request
// FF FF id 04 02 38 08 chk on the master stream, one byte per beat, tlast on
// the checksum byte. Received bytes (tuser 1) and microsecond ticks (tuser 2)
// are then taken one per cycle unless the input stalls; after 14 bytes, or
// when the tick count reaches timeout_ticks, one report beat with tlast set
// comes out. Items that cause no result are likewise taken every cycle
// unless the input stalls. After a start is taken, the slave side is held
// while its request bytes leave, one per cycle while the downstream side
// takes them, through the single output register, which request bytes and
// reports share; the input stalls while that register is held by the
// downstream side. Config writes are taken every cycle.
// ----------------------------------------------------------------------------
module servo_telemetry_read_engine_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config: timeout_ticks
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    // input items
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [7:0] servo_id, [15:8] rx_byte
    input  wire logic [1:0]  i_s_tuser,   // [1:0] cmd
    // result items
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [71:0]      o_m_tdata,   // [7:0] tx_byte, [8] report_ok,
                                          // [25:9] position_steps,
                                          // [41:26] speed_steps,
                                          // [52:42] load_value,
                                          // [60:53] voltage_tenths,
                                          // [68:61] temperature_c, [71:69] zero
    output logic             o_m_tuser,   // [0] kind
    output logic             o_m_tlast    // last
);
    import stre_pkg::*;

    // Request byte by position
    function automatic logic [7:0] req_byte(input logic [2:0] idx, input logic [7:0] id);
        logic [7:0] b;
        case (idx)
            3'd0, 3'd1: b = HDR_BYTE;
            3'd2:       b = id;
            3'd3:       b = REQ_LEN_FIELD;
            3'd4:       b = REQ_INSTR;
            3'd5:       b = REQ_ADDR;
            3'd6:       b = REQ_COUNT;
            default:    b = ~(id + REQ_LEN_FIELD + REQ_INSTR + REQ_ADDR + REQ_COUNT);
        endcase
        return b;
    endfunction

    // Report payload from the response data bytes
    function automatic logic [71:0] report_word(input logic ok, input logic [7:0][7:0] d);
        logic [16:0] pos;
        logic [15:0] spd_raw, spd;
        logic [15:0] ld_raw;
        logic [10:0] ld;
        logic [71:0] w;
        pos     = {1'b0, d[1], d[0]} - CENTER_STEPS;
        spd_raw = {d[3], d[2]};
        spd     = spd_raw[15] ? (16'd0 - {1'b0, spd_raw[14:0]}) : {1'b0, spd_raw[14:0]};
        ld_raw  = {d[5], d[4]};
        ld      = ld_raw[10] ? (11'd0 - {1'b0, ld_raw[9:0]}) : {1'b0, ld_raw[9:0]};
        w       = '0;
        if (ok) begin
            w[8]     = 1'b1;
            w[25:9]  = pos;
            w[41:26] = spd;
            w[52:42] = ld;
            w[60:53] = d[6];
            w[68:61] = d[7];
        end
        return w;
    endfunction

    logic [15:0]      r_timeout;
    logic             r_out_valid, n_out_valid;
    logic             r_out_kind, n_out_kind;
    logic             r_out_last, n_out_last;
    logic [71:0]      r_out_data, n_out_data;
    logic             r_req_busy, n_req_busy;
    logic [2:0]       r_req_idx, n_req_idx;
    logic [7:0]       r_req_id, n_req_id;

    logic             s_acc;
    logic             out_take;
    t_rx_event        rx_event;
    logic [7:0][7:0]  rx_data;

    assign o_cfg_ready = 1'b1;
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign out_take    = r_out_valid && i_m_tready;
    assign o_s_tready  = !r_req_busy && (!r_out_valid || i_m_tready);

    // Response collector
    stre_rx_collect u_rx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (s_acc),
        .i_cmd      (i_s_tuser),
        .i_servo_id (i_s_tdata[7:0]),
        .i_rx_byte  (i_s_tdata[15:8]),
        .i_timeout  (r_timeout),
        .o_event    (rx_event),
        .o_data     (rx_data)
    );

    // Timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout <= i_cfg_data;
        end
    end

    // Output register loading: request bytes first, then new items
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_last  = r_out_last;
        n_out_data  = r_out_data;
        n_req_busy  = r_req_busy;
        n_req_idx   = r_req_idx;
        n_req_id    = r_req_id;
        if (out_take) begin
            n_out_valid = 1'b0;
        end
        if (r_req_busy && out_take) begin
            n_out_valid = 1'b1;
            n_out_kind  = 1'b0;
            n_out_last  = (r_req_idx == 3'd7);
            n_out_data  = {64'd0, req_byte(r_req_idx, r_req_id)};
            n_req_idx   = r_req_idx + 3'd1;
            if (r_req_idx == 3'd7) begin
                n_req_busy = 1'b0;
            end
        end else if (s_acc && i_s_tuser == CMD_START) begin
            n_out_valid = 1'b1;
            n_out_kind  = 1'b0;
            n_out_last  = 1'b0;
            n_out_data  = {64'd0, req_byte(3'd0, i_s_tdata[7:0])};
            n_req_busy  = 1'b1;
            n_req_idx   = 3'd1;
            n_req_id    = i_s_tdata[7:0];
        end else if (s_acc && rx_event.done) begin
            n_out_valid = 1'b1;
            n_out_kind  = 1'b1;
            n_out_last  = 1'b1;
            n_out_data  = report_word(rx_event.ok, rx_data);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_req_busy  <= 1'b0;
            r_req_idx   <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_req_busy  <= n_req_busy;
            r_req_idx   <= n_req_idx;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_last <= n_out_last;
        r_out_data <= n_out_data;
        r_req_id   <= n_req_id;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = r_out_data;

    // Assertions
    a_start_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tuser == CMD_START) |=>
            (o_m_tvalid && !o_m_tuser && !o_m_tlast && o_m_tdata[7:0] == HDR_BYTE))
        else $error("start did not produce a request header byte");

    a_report_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("report without tlast");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser && !o_m_tdata[8]) |-> (o_m_tdata[71:9] == '0))
        else $error("failed report carries nonzero data");

    a_req_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser && o_m_tlast) |-> !r_req_busy)
        else $error("request tlast while bytes still pending");

endmodule
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the servo telemetry read engine.
// ----------------------------------------------------------------------------
// Drives start, byte and tick commands on the slave stream and predicts every
// request byte and telemetry report that must leave the master stream. Each
// report is compared field by field against the predicted one. Both stream
// sides idle at random. The receiver also holds off for a long stretch so
// that the output register backs up into the input. The response timeout is
// reprogrammed between phases, including its zero, one and full-scale values.
// ----------------------------------------------------------------------------
module tb;
    import stre_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         SETTLE_GAP  = 20;
    localparam int         RANDOM_ITEMS = 300;

    typedef enum logic { RD_IDLE, RD_WAIT } t_read_phase;

    typedef enum int { FLAW_NONE, FLAW_HDR0, FLAW_HDR1, FLAW_ID, FLAW_SUM } t_flaw;

    typedef struct {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic        ok;
        logic [16:0] position;
        logic [15:0] speed;
        logic [10:0] load;
        logic [7:0]  voltage;
        logic [7:0]  temperature;
    } t_telemetry_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [71:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    // Mirror of the engine state
    logic [15:0] mdl_timeout;
    t_read_phase mdl_phase;
    logic [7:0]  mdl_id;
    int          mdl_index;
    logic [15:0] mdl_ticks;
    logic [7:0]  mdl_store [RSP_BYTES];

    t_telemetry_beat pending_beats[$];

    int errors;
    int cycle_count;
    int items_sent;
    int s_gap_max;
    int m_gap_max;
    int stall_left;
    int hold_left;

    servo_telemetry_read_engine_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    // Header, id and inverted-sum checksum of the stored response
    function automatic logic response_good();
        logic [7:0] sum;
        sum = '0;
        for (int i = 2; i < RSP_BYTES - 1; i++) sum += mdl_store[i];
        return mdl_store[0] == HDR_BYTE && mdl_store[1] == HDR_BYTE &&
               mdl_store[2] == mdl_id && mdl_store[RSP_BYTES - 1] == ~sum;
    endfunction

    task automatic push_report(logic ok);
        t_telemetry_beat b;
        logic [15:0]     pos_raw;
        logic [15:0]     spd_raw;
        logic [15:0]     ld_raw;
        b = '{default: '0};
        b.kind = 1'b1;
        b.last = 1'b1;
        if (ok) begin
            pos_raw = {mdl_store[DATA_FIRST + 1], mdl_store[DATA_FIRST]};
            spd_raw = {mdl_store[DATA_FIRST + 3], mdl_store[DATA_FIRST + 2]};
            ld_raw  = {mdl_store[DATA_FIRST + 5], mdl_store[DATA_FIRST + 4]};
            b.ok       = 1'b1;
            b.position = {1'b0, pos_raw} - CENTER_STEPS;
            // sign-magnitude to two's complement
            b.speed = spd_raw[15] ? -{1'b0, spd_raw[14:0]} : {1'b0, spd_raw[14:0]};
            b.load  = ld_raw[10] ? -{1'b0, ld_raw[9:0]} : {1'b0, ld_raw[9:0]};
            b.voltage     = mdl_store[DATA_FIRST + 6];
            b.temperature = mdl_store[DATA_FIRST + 7];
        end
        pending_beats.push_back(b);
    endtask

    // Advance the mirror by one accepted request and queue its beats
    task automatic compute_beats(logic [1:0] cmd, logic [7:0] id, logic [7:0] rx);
        logic [7:0]      req [8];
        logic [7:0]      sum;
        t_telemetry_beat b;
        case (cmd)
            CMD_START: begin
                sum = id + REQ_LEN_FIELD + REQ_INSTR + REQ_ADDR + REQ_COUNT;
                req = '{HDR_BYTE, HDR_BYTE, id, REQ_LEN_FIELD, REQ_INSTR,
                        REQ_ADDR, REQ_COUNT, ~sum};
                for (int k = 0; k < 8; k++) begin
                    b = '{default: '0};
                    b.tx_byte = req[k];
                    b.last = (k == 7);
                    pending_beats.push_back(b);
                end
                mdl_id    = id;
                mdl_index = 0;
                mdl_ticks = '0;
                mdl_phase = RD_WAIT;
            end
            CMD_BYTE: begin
                if (mdl_phase == RD_WAIT) begin
                    mdl_store[mdl_index] = rx;
                    mdl_index++;
                    if (mdl_index == RSP_BYTES) begin
                        push_report(response_good());
                        mdl_phase = RD_IDLE;
                        mdl_index = 0;
                        mdl_ticks = '0;
                    end
                end
            end
            CMD_TICK: begin
                if (mdl_phase == RD_WAIT) begin
                    if (mdl_ticks != TICKS_MAX) mdl_ticks++;
                    if (mdl_ticks >= mdl_timeout) begin
                        push_report(1'b0);
                        mdl_phase = RD_IDLE;
                        mdl_index = 0;
                        mdl_ticks = '0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Send one request on the slave stream; called and returns at a falling edge
    task automatic send_item(logic [1:0] cmd, logic [7:0] id, logic [7:0] rx);
        int gap;
        gap = $urandom_range(0, s_gap_max);
        if (gap != 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = cmd;
        i_s_tdata  = {rx, id};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (cmd == CMD_START || (cmd != CMD_UNUSED && mdl_phase == RD_WAIT)) items_sent++;
        compute_beats(cmd, id, rx);
        @(negedge i_clk);
    endtask

    // Wait until every predicted beat is out, plus a quiet stretch
    task automatic settle();
        i_s_tvalid = 1'b0;
        while (pending_beats.size() != 0) @(negedge i_clk);
        repeat (SETTLE_GAP) @(negedge i_clk);
    endtask

    // Feed filler bytes until a pending read completes
    task automatic close_read();
        while (mdl_phase == RD_WAIT) send_item(CMD_BYTE, rnd8(), rnd8());
    endtask

    task automatic write_timeout(logic [15:0] value);
        close_read();
        settle();
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mdl_timeout = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Status response: FF FF id len err d0..d7 chk, first count bytes sent
    task automatic send_response(logic [7:0] id, logic [63:0] payload, t_flaw flaw,
                                 int count, int tick_pct);
        logic [7:0] pkt [RSP_BYTES];
        logic [7:0] sum;
        logic [7:0] bump;
        bump   = 8'($urandom_range(1, 255));
        pkt[0] = HDR_BYTE;
        pkt[1] = HDR_BYTE;
        pkt[2] = id;
        pkt[3] = rnd8();
        pkt[4] = rnd8();
        for (int k = 0; k < DATA_BYTES; k++) pkt[DATA_FIRST + k] = payload[8 * k +: 8];
        case (flaw)
            FLAW_HDR0: pkt[0] ^= bump;
            FLAW_HDR1: pkt[1] ^= bump;
            FLAW_ID:   pkt[2] ^= bump;
            default:   ;
        endcase
        sum = '0;
        for (int i = 2; i < RSP_BYTES - 1; i++) sum += pkt[i];
        pkt[RSP_BYTES - 1] = ~sum;
        if (flaw == FLAW_SUM) pkt[RSP_BYTES - 1] ^= bump;
        for (int i = 0; i < count; i++) begin
            while ($urandom_range(0, 99) < tick_pct) send_item(CMD_TICK, rnd8(), rnd8());
            send_item(CMD_BYTE, rnd8(), pkt[i]);
        end
    endtask

    // Receiver: long hold-off first, then the per-beat stall
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_tready = 1'b0;
        end else begin
            i_m_tready = 1'b1;
        end
    end

    task automatic compare_field(string name, logic [16:0] exp_v, logic [16:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t %s: expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // Compare each accepted beat with the oldest prediction
    always @(posedge i_clk) begin : check_beats
        t_telemetry_beat b;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_beats.size() == 0) begin
                errors++;
                $display("%0t unexpected beat: expected none, actual %h user %b last %b",
                         $time, o_m_tdata, o_m_tuser, o_m_tlast);
            end else begin
                b = pending_beats.pop_front();
                compare_field("kind", b.kind, o_m_tuser);
                compare_field("tx_byte", b.tx_byte, o_m_tdata[7:0]);
                compare_field("last", b.last, o_m_tlast);
                compare_field("report_ok", b.ok, o_m_tdata[8]);
                compare_field("position_steps", b.position, o_m_tdata[25:9]);
                compare_field("speed_steps", b.speed, o_m_tdata[41:26]);
                compare_field("load_value", b.load, o_m_tdata[52:42]);
                compare_field("voltage_tenths", b.voltage, o_m_tdata[60:53]);
                compare_field("temperature_c", b.temperature, o_m_tdata[68:61]);
            end
            stall_left = $urandom_range(0, m_gap_max);
        end
    end

    // Bytes, ticks and the unused code while idle give nothing
    task automatic test_ignored_items();
        send_item(CMD_BYTE, rnd8(), rnd8());
        send_item(CMD_TICK, rnd8(), rnd8());
        send_item(CMD_UNUSED, rnd8(), rnd8());
    endtask

    // Restart drops the first read; sign bits with zero magnitude, top values
    task automatic test_restart_and_read();
        send_item(CMD_START, 8'hA5, rnd8());
        send_item(CMD_START, 8'hFF, rnd8());
        send_response(8'hFF, {8'h00, 8'hFF, 16'h0400, 16'h8000, 16'hFFFF}, FLAW_NONE, 14, 0);
    endtask

    // Timeout of zero and of one: the first tick fails the read
    task automatic test_timeout_extremes();
        write_timeout(16'd0);
        send_item(CMD_START, 8'h00, rnd8());
        send_item(CMD_TICK, rnd8(), rnd8());
        write_timeout(16'd1);
        send_item(CMD_START, rnd8(), rnd8());
        send_item(CMD_TICK, rnd8(), rnd8());
    endtask

    // Mostly well-formed reads with random data, some flawed, cut short or noisy
    task automatic test_random_reads();
        logic [15:0] timeouts [6];
        int          tick_pcts [6];
        int          goal;
        logic [7:0]  id;
        logic [63:0] payload;
        t_flaw       flaw;
        int          count;
        timeouts  = '{16'hFFFF, 16'd3, 16'($urandom_range(1, 20)), TIMEOUT_RESET,
                      16'($urandom_range(1, 65535)), 16'd2};
        tick_pcts = '{25, 15, 10, 30, 20, 10};
        for (int p = 0; p < 6; p++) begin
            write_timeout(timeouts[p]);
            s_gap_max = (p == 2) ? 0 : 19;
            m_gap_max = (p == 4) ? 0 : 19;
            goal = items_sent + RANDOM_ITEMS / 6;
            while (items_sent < goal) begin
                id      = rnd8();
                payload = {$urandom, $urandom};
                if ($urandom_range(0, 7) == 0) payload[31:16] = 16'h8000;
                if ($urandom_range(0, 7) == 0) payload[47:32] = 16'h0400;
                flaw  = ($urandom_range(0, 99) < 70) ? FLAW_NONE
                                                      : t_flaw'($urandom_range(1, 4));
                count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 13) : RSP_BYTES;
                send_item(CMD_START, id, rnd8());
                send_response(id, payload, flaw, count, tick_pcts[p]);
                if ($urandom_range(0, 9) == 0)
                    send_item(2'($urandom_range(1, 3)), rnd8(), rnd8());
            end
        end
    endtask

    // Receiver holds off while starts keep coming, so the input stalls
    task automatic test_backpressure();
        logic [7:0] id;
        close_read();
        s_gap_max = 0;
        m_gap_max = 0;
        @(posedge i_clk);
        hold_left = 300;
        @(negedge i_clk);
        for (int r = 0; r < 3; r++) begin
            id = rnd8();
            send_item(CMD_START, id, rnd8());
            send_response(id, {$urandom, $urandom}, FLAW_NONE, RSP_BYTES, 0);
        end
        m_gap_max = 19;
        s_gap_max = 19;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_m_tready  = 1'b0;
        errors      = 0;
        cycle_count = 0;
        items_sent  = 0;
        s_gap_max   = 19;
        m_gap_max   = 19;
        stall_left  = 0;
        hold_left   = 0;
        mdl_timeout = TIMEOUT_RESET;
        mdl_phase   = RD_IDLE;
        mdl_id      = '0;
        mdl_index   = 0;
        mdl_ticks   = '0;
        foreach (mdl_store[i]) mdl_store[i] = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_ignored_items();
        test_restart_and_read();
        test_timeout_extremes();
        test_random_reads();
        test_backpressure();

        settle();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
